### src/lsfp_pkg.sv
// Shared types and constants for the LED stream frame parser.
`default_nettype none

package lsfp_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned INDEX_W = 16;
   localparam int unsigned HPOS_W  = 3;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic [BYTE_W-1:0] HDR_CHAR_0 = 8'h41;  // 'A'
   localparam logic [BYTE_W-1:0] HDR_CHAR_1 = 8'h64;  // 'd'
   localparam logic [BYTE_W-1:0] HDR_CHAR_2 = 8'h61;  // 'a'
   localparam logic [BYTE_W-1:0] CHECK_XOR  = 8'h55;
   localparam logic [BYTE_W-1:0] GAP_LIMIT_RESET = 8'd10;
   localparam logic [BYTE_W-1:0] TICKS_MAX  = 8'hFF;

   localparam logic [HPOS_W-1:0] HPOS_IDLE  = 3'd0;
   localparam logic [HPOS_W-1:0] HPOS_GOT_A = 3'd1;
   localparam logic [HPOS_W-1:0] HPOS_GOT_D = 3'd2;
   localparam logic [HPOS_W-1:0] HPOS_GOT_HDR = 3'd3;
   localparam logic [HPOS_W-1:0] HPOS_GOT_HI  = 3'd4;
   localparam logic [HPOS_W-1:0] HPOS_GOT_LO  = 3'd5;

   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_GREEN  = 4'b0010,
      PH_RED    = 4'b0100,
      PH_BLUE   = 4'b1000
   } phase_type;

endpackage

`default_nettype wire

### src/led_stream_frame_parser.sv
// Each input transaction passes through the input register, then its result is held in the result register.
// Throughput: one input transaction per cycle; the input register and the
// result register each stall only when the result register is full and not taken.
// Reset (synchronous, active high) returns the parser to header hunting, clears
// all counters and held colors, and sets the gap limit to 10 ticks.
`default_nettype none

module led_stream_frame_parser
   import lsfp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_kind,
   input  wire logic [BYTE_W-1:0]    req_data_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [INDEX_W-1:0]        rsp_led_index,
   output logic [BYTE_W-1:0]         rsp_red,
   output logic [BYTE_W-1:0]         rsp_green,
   output logic [BYTE_W-1:0]         rsp_blue,
   output logic                      rsp_last_of_frame,
   input  wire logic                 csr_wr_en,
   input  wire logic [BYTE_W-1:0]    csr_wr_data
);

   // Input register.
   logic              in_valid_ff;
   logic              in_kind_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   // Parser state.
   logic [BYTE_W-1:0]  gap_limit_ff;
   phase_type          phase_ff, phase_in;
   logic [HPOS_W-1:0]  header_pos_ff, header_pos_in;
   logic [INDEX_W-1:0] frame_length_ff, frame_length_in;
   logic [INDEX_W-1:0] led_counter_ff, led_counter_in;
   logic [BYTE_W-1:0]  held_green_ff, held_green_in;
   logic [BYTE_W-1:0]  held_red_ff, held_red_in;
   logic [BYTE_W-1:0]  idle_ticks_ff, idle_ticks_in;

   // Result register.
   logic               out_valid_ff;
   logic [INDEX_W-1:0] out_index_ff;
   logic [BYTE_W-1:0]  out_red_ff, out_green_ff, out_blue_ff;
   logic               out_last_ff;

   logic               proc_fire;
   logic               emit;
   logic               emit_last;
   logic               timeout;
   phase_type          phase_eff;
   logic [HPOS_W-1:0]  hpos_eff;
   logic [INDEX_W-1:0] counter_eff;
   logic [BYTE_W-1:0]  green_eff, red_eff;
   logic [BYTE_W-1:0]  check_byte;
   logic [INDEX_W:0]   next_count;

   // The stored transaction is processed unless the result register is full and stalled.
   assign proc_fire = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || proc_fire;

   assign timeout    = idle_ticks_ff > gap_limit_ff;
   assign phase_eff  = timeout ? PH_HEADER : phase_ff;
   assign hpos_eff   = timeout ? HPOS_IDLE : header_pos_ff;
   assign counter_eff = timeout ? '0 : led_counter_ff;
   assign green_eff  = timeout ? '0 : held_green_ff;
   assign red_eff    = timeout ? '0 : held_red_ff;
   assign check_byte = frame_length_ff[INDEX_W-1:BYTE_W] ^ frame_length_ff[BYTE_W-1:0]
                       ^ CHECK_XOR;
   assign next_count = {1'b0, counter_eff} + {{INDEX_W{1'b0}}, 1'b1};
   assign emit_last  = next_count >= {1'b0, frame_length_ff};

   always_comb begin
      phase_in        = phase_ff;
      header_pos_in   = header_pos_ff;
      frame_length_in = frame_length_ff;
      led_counter_in  = led_counter_ff;
      held_green_in   = held_green_ff;
      held_red_in     = held_red_ff;
      idle_ticks_in   = idle_ticks_ff;
      emit            = 1'b0;
      if (in_kind_ff == KIND_TICK) begin
         if (idle_ticks_ff != TICKS_MAX) begin
            idle_ticks_in = idle_ticks_ff + 8'd1;
         end
      end else begin
         phase_in       = phase_eff;
         header_pos_in  = hpos_eff;
         led_counter_in = counter_eff;
         held_green_in  = green_eff;
         held_red_in    = red_eff;
         idle_ticks_in  = '0;
         unique case (phase_eff)
            PH_HEADER: begin
               if (hpos_eff == HPOS_IDLE && in_byte_ff == HDR_CHAR_0) begin
                  header_pos_in = HPOS_GOT_A;
               end else if (hpos_eff == HPOS_GOT_A && in_byte_ff == HDR_CHAR_1) begin
                  header_pos_in = HPOS_GOT_D;
               end else if (hpos_eff == HPOS_GOT_D && in_byte_ff == HDR_CHAR_2) begin
                  header_pos_in = HPOS_GOT_HDR;
               end else if (hpos_eff == HPOS_GOT_HDR) begin
                  frame_length_in = {in_byte_ff, {BYTE_W{1'b0}}};
                  header_pos_in   = HPOS_GOT_HI;
               end else if (hpos_eff == HPOS_GOT_HI) begin
                  frame_length_in = {frame_length_ff[INDEX_W-1:BYTE_W], in_byte_ff};
                  header_pos_in   = HPOS_GOT_LO;
               end else if (hpos_eff == HPOS_GOT_LO) begin
                  if (in_byte_ff == check_byte) begin
                     phase_in       = PH_GREEN;
                     led_counter_in = '0;
                  end else begin
                     frame_length_in = '0;
                  end
                  header_pos_in = HPOS_IDLE;
               end else begin
                  // Mismatched header byte, or an unused position: start over.
                  header_pos_in   = HPOS_IDLE;
                  frame_length_in = '0;
               end
            end
            PH_GREEN: begin
               held_green_in = in_byte_ff;
               phase_in      = PH_RED;
            end
            PH_RED: begin
               held_red_in = in_byte_ff;
               phase_in    = PH_BLUE;
            end
            PH_BLUE: begin
               emit          = 1'b1;
               held_green_in = '0;
               held_red_in   = '0;
               if (emit_last) begin
                  phase_in = PH_HEADER;
               end else begin
                  led_counter_in = next_count[INDEX_W-1:0];
                  phase_in       = PH_GREEN;
               end
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_kind_ff <= req_kind;
         in_byte_ff <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_limit_ff <= GAP_LIMIT_RESET;
      end else if (csr_wr_en) begin
         gap_limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         header_pos_ff   <= HPOS_IDLE;
         frame_length_ff <= '0;
         led_counter_ff  <= '0;
         held_green_ff   <= '0;
         held_red_ff     <= '0;
         idle_ticks_ff   <= '0;
      end else if (proc_fire) begin
         phase_ff        <= phase_in;
         header_pos_ff   <= header_pos_in;
         frame_length_ff <= frame_length_in;
         led_counter_ff  <= led_counter_in;
         held_green_ff   <= held_green_in;
         held_red_ff     <= held_red_in;
         idle_ticks_ff   <= idle_ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (proc_fire) begin
         out_valid_ff <= emit;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_fire && emit) begin
         out_index_ff <= counter_eff;
         out_red_ff   <= red_eff;
         out_green_ff <= green_eff;
         out_blue_ff  <= in_byte_ff;
         out_last_ff  <= emit_last;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_led_index     = out_index_ff;
   assign rsp_red           = out_red_ff;
   assign rsp_green         = out_green_ff;
   assign rsp_blue          = out_blue_ff;
   assign rsp_last_of_frame = out_last_ff;

`ifndef SYNTHESIS
   // The header position never reaches the unused codes.
   a_hpos_range: assert property (@(posedge clock) disable iff (reset)
      header_pos_ff <= HPOS_GOT_LO)
      else $error("header position out of range");

   // A stored transaction that cannot be processed stays in the input register.
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !proc_fire |=> in_valid_ff && $stable(in_kind_ff) && $stable(in_byte_ff))
      else $error("stalled input transaction lost");

   // A processed tick below saturation advances the idle count by exactly one.
   a_tick_count: assert property (@(posedge clock) disable iff (reset)
      proc_fire && in_kind_ff == KIND_TICK && idle_ticks_ff != TICKS_MAX
      |=> idle_ticks_ff == $past(idle_ticks_ff) + 8'd1)
      else $error("idle tick count did not advance");
`endif

endmodule

`default_nettype wire
